[rtl/core/loc_pkg.sv]
package loc_pkg;

  localparam logic [15:0] OPACITY_ONE = 16'd32768;
  localparam logic [16:0] RECIP_255 = 17'd65793;
  localparam logic [16:0] HALF_WEIGHT = 17'd32768;
  localparam int FRAC_BITS = 16;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES = FRAC_BITS / DIV_STEPS;
  localparam int LANES = 2;

  typedef enum logic {
    REG_TOP_OPACITY = 1'b0,
    REG_BOTTOM_OPACITY = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t top;
    rgb_t bottom;
  } pix_t;

  function automatic logic [15:0] sat_opacity(input logic [15:0] op);
    return (op > OPACITY_ONE) ? OPACITY_ONE : op;
  endfunction

  function automatic logic [17:0] div_step(input logic [16:0] rem, input logic [16:0] dvs);
    logic [17:0] sh;
    logic [17:0] diff;
    logic ge;
    sh = {rem, 1'b0};
    diff = sh - {1'b0, dvs};
    ge = (sh >= {1'b0, dvs});
    return {ge, ge ? diff[16:0] : sh[16:0]};
  endfunction

  function automatic logic [7:0] clamp_color(input logic [9:0] v);
    return (v > 10'd255) ? 8'd255 : v[7:0];
  endfunction

endpackage

[rtl/core/layer_over_composite.sv]
// Straight-alpha "over" compositing of a top pixel onto a bottom pixel.
// Input requests arrive on s_tvalid/s_tready/s_tdata, one pair of pixels each;
// results leave on m_tvalid/m_tready/m_tdata, one composited pixel each.
// Every layer alpha is scaled by its opacity register, written through
// cfg_we/cfg_index/cfg_data; the user must write it only while no request is
// in flight, and the block itself does not enforce this.
// The datapath is a 12-stage pipeline: two stages of multiplies for the layer
// alphas and their division by 255, one correction stage, the alpha product,
// the combined alpha, then a restoring divider for the two color weights that
// resolves the integer bit in one stage and four fraction bits in each of four
// further stages, then the weight multiplies and the final sum and clamp.
// Throughput is one pixel per clock while the receiver holds m_tready high.
// Each stage holds its request until the next stage can take it, so a stalled
// receiver fills the bubbles first and only then deasserts s_tready; nothing
// is dropped or repeated.
// Reset empties the pipeline and sets both opacities to 1.0.
module layer_over_composite
  import loc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // top_blue, top_green, top_red, top_alpha,
  // bottom_blue, bottom_green, bottom_red, bottom_alpha
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_blue, out_green, out_red, out_alpha
  output logic [31:0] m_tdata
);

  localparam int DIV_BASE = 5;
  localparam int PROD_STAGE = DIV_BASE + DIV_STAGES + 1;
  localparam int OUT_STAGE = PROD_STAGE + 1;
  localparam int N_STAGES = OUT_STAGE + 1;

  logic [15:0] top_opacity;
  logic [15:0] bottom_opacity;

  logic [N_STAGES-1:0] v;
  logic [N_STAGES-1:0] en;

  pix_t pix [PROD_STAGE];

  logic [23:0] x_top, x_bot;
  logic [23:0] x1_top, x1_bot;
  logic [16:0] qe_top, qe_bot;
  logic [16:0] a2, b2;
  logic [16:0] a3, b3, p3;
  logic [16:0] c4, na4, b4;

  logic [16:0]           dc    [DIV_STAGES+1];
  logic [LANES-1:0][16:0] drem [DIV_STAGES+1];
  logic [LANES-1:0][16:0] dquo [DIV_STAGES+1];
  logic                  dzero [DIV_STAGES+1];
  logic [7:0]            doa   [DIV_STAGES+1];

  logic [24:0] prod [6];
  logic [7:0]  oa10;
  rgb_t        out_pix;
  logic [7:0]  out_alpha;

  pix_t        in_pix;
  logic [22:0] mul_top, mul_bot;
  logic [40:0] rec_top, rec_bot;
  logic [24:0] rem_top, rem_bot;
  logic [33:0] ab;
  logic [17:0] sum_ab;
  logic [24:0] c255;
  logic [16:0] wb, wt;
  logic [25:0] sum_b, sum_g, sum_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_opacity <= OPACITY_ONE;
      bottom_opacity <= OPACITY_ONE;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_TOP_OPACITY:    top_opacity <= cfg_data;
        REG_BOTTOM_OPACITY: bottom_opacity <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[N_STAGES-1] = !v[N_STAGES-1] || m_tready;
    for (int i = N_STAGES - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[N_STAGES-1];
  assign m_tdata = {out_alpha, out_pix.red, out_pix.green, out_pix.blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_tvalid;
      end
      for (int i = 1; i < N_STAGES; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Layer alphas: 2 * byte * opacity, then divided by 255.
  always_comb begin
    in_pix.top.blue = s_tdata[7:0];
    in_pix.top.green = s_tdata[15:8];
    in_pix.top.red = s_tdata[23:16];
    in_pix.bottom.blue = s_tdata[39:32];
    in_pix.bottom.green = s_tdata[47:40];
    in_pix.bottom.red = s_tdata[55:48];
    mul_top = 23'(s_tdata[31:24]) * 23'(sat_opacity(top_opacity));
    mul_bot = 23'(s_tdata[63:56]) * 23'(sat_opacity(bottom_opacity));
    rec_top = 41'(x_top) * 41'(RECIP_255);
    rec_bot = 41'(x_bot) * 41'(RECIP_255);
    rem_top = 25'(x1_top) - ({qe_top, 8'b0} - {8'b0, qe_top});
    rem_bot = 25'(x1_bot) - ({qe_bot, 8'b0} - {8'b0, qe_bot});
    ab = 34'(a2) * 34'(b2);
    sum_ab = 18'(a3) + 18'(b3) - 18'(p3);
    c255 = {c4, 8'b0} - {8'b0, c4};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pix[0] <= in_pix;
      x_top <= {mul_top, 1'b0};
      x_bot <= {mul_bot, 1'b0};
    end
    if (en[1]) begin
      x1_top <= x_top;
      x1_bot <= x_bot;
      qe_top <= rec_top[40:24];
      qe_bot <= rec_bot[40:24];
    end
    if (en[2]) begin
      b2 <= (rem_top >= 25'd255) ? qe_top + 17'd1 : qe_top;
      a2 <= (rem_bot >= 25'd255) ? qe_bot + 17'd1 : qe_bot;
    end
    if (en[3]) begin
      a3 <= a2;
      b3 <= b2;
      p3 <= ab[32:16];
    end
    if (en[4]) begin
      c4 <= sum_ab[16:0];
      na4 <= a3 - p3;
      b4 <= b3;
    end
    if (en[DIV_BASE]) begin
      dc[0] <= c4;
      dzero[0] <= (c4 == 17'd0);
      doa[0] <= c255[23:16];
      dquo[0][0] <= {16'b0, na4 >= c4};
      drem[0][0] <= (na4 >= c4) ? na4 - c4 : na4;
      dquo[0][1] <= {16'b0, b4 >= c4};
      drem[0][1] <= (b4 >= c4) ? b4 - c4 : b4;
    end
  end

  for (genvar i = 1; i < PROD_STAGE; i++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en[i]) begin
        pix[i] <= pix[i-1];
      end
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [LANES-1:0][16:0] rem_w;
    logic [LANES-1:0][16:0] quo_w;

    always_comb begin
      logic [17:0] st;
      st = '0;
      rem_w = drem[k-1];
      quo_w = dquo[k-1];
      for (int l = 0; l < LANES; l++) begin
        for (int s = 0; s < DIV_STEPS; s++) begin
          st = div_step(rem_w[l], dc[k-1]);
          rem_w[l] = st[16:0];
          quo_w[l] = {quo_w[l][15:0], st[17]};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[DIV_BASE+k]) begin
        dc[k] <= dc[k-1];
        dzero[k] <= dzero[k-1];
        doa[k] <= doa[k-1];
        drem[k] <= rem_w;
        dquo[k] <= quo_w;
      end
    end
  end

  always_comb begin
    wb = dzero[DIV_STAGES] ? HALF_WEIGHT : dquo[DIV_STAGES][0];
    wt = dzero[DIV_STAGES] ? HALF_WEIGHT : dquo[DIV_STAGES][1];
    sum_b = 26'(prod[0]) + 26'(prod[3]);
    sum_g = 26'(prod[1]) + 26'(prod[4]);
    sum_r = 26'(prod[2]) + 26'(prod[5]);
  end

  always_ff @(posedge clk) begin
    if (en[PROD_STAGE]) begin
      prod[0] <= 25'(wb) * 25'(pix[PROD_STAGE-1].bottom.blue);
      prod[1] <= 25'(wb) * 25'(pix[PROD_STAGE-1].bottom.green);
      prod[2] <= 25'(wb) * 25'(pix[PROD_STAGE-1].bottom.red);
      prod[3] <= 25'(wt) * 25'(pix[PROD_STAGE-1].top.blue);
      prod[4] <= 25'(wt) * 25'(pix[PROD_STAGE-1].top.green);
      prod[5] <= 25'(wt) * 25'(pix[PROD_STAGE-1].top.red);
      oa10 <= doa[DIV_STAGES];
    end
    if (en[OUT_STAGE]) begin
      out_pix.blue <= clamp_color(sum_b[25:16]);
      out_pix.green <= clamp_color(sum_g[25:16]);
      out_pix.red <= clamp_color(sum_r[25:16]);
      out_alpha <= oa10;
    end
  end

endmodule
